[rtl/scre_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scre_pkg
// Shared types, field widths and codes of the serial command retry engine.
// ----------------------------------------------------------------------------
package scre_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int FRAME_BYTES     = 12;
	localparam int FRAME_W         = FRAME_BYTES * 8;
	localparam int BODY_BYTES      = FRAME_BYTES - 1;
	localparam int BODY_W          = BODY_BYTES * 8;
	localparam int CFG_W           = 16;

	localparam logic [15:0] RETRY_WAIT_RST  = 16'd100;
	localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;

	// input opcodes
	localparam logic [1:0] OPC_QUEUE = 2'd0;
	localparam logic [1:0] OPC_REPLY = 2'd1;
	localparam logic [1:0] OPC_TICK  = 2'd2;

	// configuration register indexes
	localparam logic CFG_RETRY_WAIT  = 1'b0;
	localparam logic CFG_RETRY_LIMIT = 1'b1;

	// result status codes
	localparam logic [3:0] ST_QUEUED      = 4'd0;
	localparam logic [3:0] ST_FULL        = 4'd1;
	localparam logic [3:0] ST_ACCEPTED    = 4'd2;
	localparam logic [3:0] ST_UNSOLICITED = 4'd3;
	localparam logic [3:0] ST_BAD_CSUM    = 4'd4;
	localparam logic [3:0] ST_REJECTED    = 4'd5;
	localparam logic [3:0] ST_ABORTED     = 4'd6;
	localparam logic [3:0] ST_BAD_ID      = 4'd7;
	localparam logic [3:0] ST_BAD_SEQ     = 4'd8;
	localparam logic [3:0] ST_TICK        = 4'd9;

	localparam logic [7:0] PAD_BYTE    = 8'hff;
	localparam logic [7:0] REJECT_MASK = 8'hf0;
	localparam logic [3:0] MAX_LEN     = 4'd11;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] frame_low;
		logic [31:0] frame_high;
		logic [3:0]  cmd_length;
	} in_item_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [3:0]  reject_reason;
		logic        tx_valid;
		logic [63:0] tx_frame_low;
		logic [31:0] tx_frame_high;
		logic        reply_accepted;
	} out_item_t;

	typedef enum logic [1:0] {
		KIND_CMD   = 2'd0,
		KIND_REPLY = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	// classified item handed from front to back
	typedef struct packed {
		kind_t             kind;
		logic [BODY_W-1:0] body;    // bytes 0..10; command has byte 1 zeroed
		logic [7:0]        sum;     // command: sum of all body bytes but byte 1
		logic              csum_ok; // reply: byte 11 matches sum of bytes 0..10
	} fe_item_t;

endpackage

[rtl/scre_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scre_front
// Accepts input items, pads and pre-sums commands, checks reply checksums,
// and holds classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module scre_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  scre_pkg::in_item_t item,
	output logic               fe_valid,
	input  logic               fe_pop,
	output scre_pkg::fe_item_t fe_item
);

	scre_pkg::fe_item_t cls;
	scre_pkg::fe_item_t slot_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               do_push;
	logic               do_pop;

	always_comb begin
		logic [7:0] in_b [scre_pkg::FRAME_BYTES];
		logic [7:0] b;
		logic [3:0] len_c;
		logic [7:0] psum;
		logic [7:0] rsum;
		for (int i = 0; i < 8; i++) begin
			in_b[i] = item.frame_low[8*i +: 8];
		end
		for (int i = 0; i < 4; i++) begin
			in_b[8 + i] = item.frame_high[8*i +: 8];
		end
		len_c = (item.cmd_length > scre_pkg::MAX_LEN) ? scre_pkg::MAX_LEN : item.cmd_length;
		psum  = '0;
		rsum  = '0;
		cls   = '0;
		unique case (item.opcode)
			scre_pkg::OPC_QUEUE: cls.kind = scre_pkg::KIND_CMD;
			scre_pkg::OPC_REPLY: cls.kind = scre_pkg::KIND_REPLY;
			scre_pkg::OPC_TICK:  cls.kind = scre_pkg::KIND_TICK;
			default:             cls.kind = scre_pkg::KIND_NOP;
		endcase
		for (int i = 0; i < scre_pkg::BODY_BYTES; i++) begin
			rsum = rsum + in_b[i];
			if (cls.kind == scre_pkg::KIND_CMD) begin
				b = (4'(i) < len_c) ? in_b[i] : scre_pkg::PAD_BYTE;
				if (i == 1) begin
					b = '0;
				end
				psum = psum + b;
			end else begin
				b = in_b[i];
			end
			cls.body[8*i +: 8] = b;
		end
		cls.sum     = psum;
		cls.csum_ok = (in_b[scre_pkg::BODY_BYTES] == rsum);
	end

	assign full     = cnt_q[1];
	assign fe_valid = (cnt_q != 2'd0);
	assign fe_item  = slot_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = fe_pop && fe_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end

endmodule

[rtl/scre_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scre_back
// Command queue memory, retry and wait state, reply checks and the result
// register. Works one classified item at a time.
// ----------------------------------------------------------------------------
module scre_back #(
	parameter int QUEUE_DEPTH = scre_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fe_valid,
	output logic                   fe_pop,
	input  scre_pkg::fe_item_t     fe_item,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [scre_pkg::CFG_W-1:0] cfg_data,
	output logic                   empty,
	input  logic                   pop,
	output scre_pkg::out_item_t    result
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_C  = AW'(QUEUE_DEPTH - 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_READ = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                       state_q;
	scre_pkg::fe_item_t           item_q;
	logic [scre_pkg::FRAME_W-1:0] mem [QUEUE_DEPTH];
	logic [scre_pkg::FRAME_W-1:0] head_q;
	logic [AW-1:0]                rd_ptr_q, wr_ptr_q, rd_ptr_n, wr_ptr_n;
	logic [CW-1:0]                cnt_q, cnt_n;
	logic [7:0]                   seq_q, seq_n;
	logic [3:0]                   retry_q, retry_n;
	logic                         waiting_q, waiting_n;
	logic [15:0]                  wait_cnt_q, wait_cnt_n;
	logic [15:0]                  cfg_wait_q;
	logic [3:0]                   cfg_limit_q;
	logic                         mem_we;
	logic [scre_pkg::FRAME_W-1:0] mem_wdata;
	logic [3:0]                   status_n, status_q;
	logic [3:0]                   reason_n, reason_q;
	logic                         acc_n, acc_q;
	logic                         send_n, send_q;
	logic                         out_valid_q;
	scre_pkg::out_item_t          out_q;
	logic                         out_load;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == LAST_C) ? '0 : p + AW'(1);
	endfunction

	always_comb begin
		logic [7:0] r0;
		logic [7:0] seq_inc;
		logic       drop;
		r0         = item_q.body[7:0];
		seq_inc    = seq_q + 8'd1;
		drop       = 1'b0;
		rd_ptr_n   = rd_ptr_q;
		wr_ptr_n   = wr_ptr_q;
		cnt_n      = cnt_q;
		seq_n      = seq_q;
		retry_n    = retry_q;
		waiting_n  = waiting_q;
		wait_cnt_n = wait_cnt_q;
		mem_we     = 1'b0;
		mem_wdata  = {item_q.sum + seq_inc, item_q.body[scre_pkg::BODY_W-1:16],
			seq_inc, item_q.body[7:0]};
		status_n   = scre_pkg::ST_TICK;
		reason_n   = '0;
		acc_n      = 1'b0;
		send_n     = 1'b0;
		unique case (item_q.kind)
			scre_pkg::KIND_CMD: begin
				if (cnt_q == DEPTH_C) begin
					status_n = scre_pkg::ST_FULL;
				end else begin
					seq_n    = seq_inc;
					mem_we   = 1'b1;
					wr_ptr_n = ptr_inc(wr_ptr_q);
					cnt_n    = cnt_q + CW'(1);
					status_n = scre_pkg::ST_QUEUED;
					send_n   = (cnt_q == '0) && !waiting_q;
				end
			end
			scre_pkg::KIND_REPLY: begin
				priority if (cnt_q == '0) begin
					status_n = scre_pkg::ST_UNSOLICITED;
				end else if (!item_q.csum_ok) begin
					drop     = 1'b1;
					status_n = scre_pkg::ST_BAD_CSUM;
				end else if ((r0 & scre_pkg::REJECT_MASK) == scre_pkg::REJECT_MASK) begin
					reason_n = r0[3:0];
					priority if (waiting_q) begin
						status_n = scre_pkg::ST_REJECTED;
					end else if ({1'b0, retry_q} + 5'd1 > {1'b0, cfg_limit_q}) begin
						drop     = 1'b1;
						status_n = scre_pkg::ST_ABORTED;
					end else begin
						retry_n    = retry_q + 4'd1;
						waiting_n  = 1'b1;
						wait_cnt_n = cfg_wait_q;
						status_n   = scre_pkg::ST_REJECTED;
					end
				end else begin
					drop = 1'b1;
					priority if (r0 != head_q[7:0]) begin
						status_n = scre_pkg::ST_BAD_ID;
					end else if (item_q.body[15:8] != head_q[15:8]) begin
						status_n = scre_pkg::ST_BAD_SEQ;
					end else begin
						status_n = scre_pkg::ST_ACCEPTED;
						acc_n    = 1'b1;
					end
				end
				if (drop) begin
					rd_ptr_n = ptr_inc(rd_ptr_q);
					cnt_n    = cnt_q - CW'(1);
					retry_n  = '0;
				end
				send_n = (cnt_n != '0) && !waiting_n;
			end
			scre_pkg::KIND_TICK: begin
				if (waiting_q) begin
					if (wait_cnt_q <= 16'd1) begin
						wait_cnt_n = '0;
						waiting_n  = 1'b0;
						send_n     = (cnt_q != '0);
					end else begin
						wait_cnt_n = wait_cnt_q - 16'd1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// head is re-read every cycle; the S_READ step after an update lets it settle
	always_ff @(posedge clk) begin
		if (state_q == S_EXEC && mem_we) begin
			mem[wr_ptr_q] <= mem_wdata;
		end
		head_q <= mem[rd_ptr_q];
		if (fe_pop) begin
			item_q <= fe_item;
		end
		if (state_q == S_EXEC) begin
			status_q <= status_n;
			reason_q <= reason_n;
			acc_q    <= acc_n;
			send_q   <= send_n;
		end
		if (out_load) begin
			out_q.status         <= status_q;
			out_q.reject_reason  <= reason_q;
			out_q.tx_valid       <= send_q;
			out_q.tx_frame_low   <= send_q ? head_q[63:0] : '0;
			out_q.tx_frame_high  <= send_q ? head_q[95:64] : '0;
			out_q.reply_accepted <= acc_q;
		end
	end

	assign fe_pop   = (state_q == S_IDLE) && fe_valid;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || pop);
	assign empty    = !out_valid_q;
	assign result   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			cnt_q       <= '0;
			seq_q       <= '0;
			retry_q     <= '0;
			waiting_q   <= 1'b0;
			wait_cnt_q  <= '0;
			cfg_wait_q  <= scre_pkg::RETRY_WAIT_RST;
			cfg_limit_q <= scre_pkg::RETRY_LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					scre_pkg::CFG_RETRY_WAIT:  cfg_wait_q  <= cfg_data;
					scre_pkg::CFG_RETRY_LIMIT: cfg_limit_q <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (fe_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					rd_ptr_q   <= rd_ptr_n;
					wr_ptr_q   <= wr_ptr_n;
					cnt_q      <= cnt_n;
					seq_q      <= seq_n;
					retry_q    <= retry_n;
					waiting_q  <= waiting_n;
					wait_cnt_q <= wait_cnt_n;
					state_q    <= S_READ;
				end
				S_READ: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/serial_command_retry_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_retry_engine_top
// Host side of a 12-byte request/reply link with reject recovery.
// ----------------------------------------------------------------------------
// Items enter as a queue: an item is taken on a clock edge with push high and
// full low. Each item is a command to queue, a reply frame, or a time tick.
// Every item gives exactly one result, shown on result while empty is low and
// taken on an edge with pop high. A result may carry a frame to send.
// The front stage takes an item each cycle, while full is low, into a two-entry
// queue. The back stage works through four steps per item: pick up, execute
// against the retry and wait state, the command memory read of the new head,
// then load the result register. It takes a new item only after the result
// of the last one is loaded.
// While a result is not popped, the back stage holds in its last step and the
// front queue fills, then full goes high. Reset clears the queues, pointers,
// counters and wait state, and loads the retry wait (100 ticks) and retry
// limit (5). The command memory has no reset. Configuration writes through
// cfg_we, cfg_index and cfg_data take effect at once and belong to idle time.
// ----------------------------------------------------------------------------
module serial_command_retry_engine_top #(
	parameter int QUEUE_DEPTH = scre_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  scre_pkg::in_item_t          item,
	output logic                        empty,
	input  logic                        pop,
	output scre_pkg::out_item_t         result,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [scre_pkg::CFG_W-1:0]  cfg_data
);

	logic               fe_valid;
	logic               fe_pop;
	scre_pkg::fe_item_t fe_item;

	scre_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.fe_valid (fe_valid),
		.fe_pop   (fe_pop),
		.fe_item  (fe_item)
	);

	scre_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fe_valid  (fe_valid),
		.fe_pop    (fe_pop),
		.fe_item   (fe_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

[rtl/scre_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scre_checker
// Port-level checks of the serial command retry engine, bound to the top.
// ----------------------------------------------------------------------------
module scre_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                empty,
	input logic                pop,
	input scre_pkg::out_item_t result
);

	// a waiting result stays put until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("result changed while stalled");

	a_idle_frame: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !result.tx_valid |->
			result.tx_frame_low == 64'd0 && result.tx_frame_high == 32'd0)
		else $error("frame bits set with no frame sent");

	a_accept_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.reply_accepted |-> result.status == scre_pkg::ST_ACCEPTED)
		else $error("reply accepted flag without accepted status");

	a_reason_status: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.reject_reason != 4'd0 |->
			result.status == scre_pkg::ST_REJECTED || result.status == scre_pkg::ST_ABORTED)
		else $error("reject reason outside a reject result");

	a_full_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result.status == scre_pkg::ST_FULL |->
			!result.tx_valid && !result.reply_accepted)
		else $error("full result sent a frame");

endmodule

bind serial_command_retry_engine_top scre_checker u_scre_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);

[bench/serial_command_retry_engine_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_command_retry_engine_top_test
// Self-checking bench for the command retry engine: a directed set of commands,
// replies and ticks that walks through checksum, id, sequence, reject, abort,
// full-queue and long-wait handling, then random traffic under several retry
// settings and idle patterns. An in-bench model of the queue, retry and wait
// state predicts every result, which is compared in arrival order.
// ----------------------------------------------------------------------------
module serial_command_retry_engine_top_test;

	localparam int QDEPTH      = scre_pkg::QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_ITEMS = 475;

	typedef enum int {
		RP_GOOD,
		RP_BAD_ID,
		RP_BAD_SEQ,
		RP_BAD_CSUM,
		RP_REJECT,
		RP_NOISE
	} reply_kind_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        push      = 1'b0;
	logic                        full;
	scre_pkg::in_item_t          item      = '0;
	logic                        empty;
	logic                        pop       = 1'b0;
	scre_pkg::out_item_t         result;
	logic                        cfg_we    = 1'b0;
	logic                        cfg_index = 1'b0;
	logic [scre_pkg::CFG_W-1:0]  cfg_data  = '0;

	int unsigned idle_pct  = 0;
	int unsigned stall_pct = 0;
	int unsigned cycles    = 0;
	int unsigned mismatches = 0;

	scre_pkg::out_item_t awaited_responses[$];

	// engine state as seen from outside
	logic [scre_pkg::FRAME_W-1:0] cmd_mem [QDEPTH];
	int unsigned                  rd_ptr, wr_ptr, fill;
	logic [7:0]                   seq_no;
	logic [3:0]                   head_retries;
	bit                           wait_active;
	logic [15:0]                  wait_left;
	logic [15:0]                  wait_setting;
	logic [3:0]                   retry_setting;

	serial_command_retry_engine_top #(.QUEUE_DEPTH(QDEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL serial_command_retry_engine_top");
			$finish;
		end
	end

	always @(negedge clk) begin
		pop <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [7:0] body_sum(input logic [scre_pkg::FRAME_W-1:0] f);
		logic [7:0] s;
		s = '0;
		for (int i = 0; i < scre_pkg::BODY_BYTES; i++)
			s += f[8*i +: 8];
		return s;
	endfunction

	function automatic bit same_result(input scre_pkg::out_item_t a,
		input scre_pkg::out_item_t b);
		return a.status === b.status && a.reject_reason === b.reject_reason &&
			a.tx_valid === b.tx_valid && a.tx_frame_low === b.tx_frame_low &&
			a.tx_frame_high === b.tx_frame_high && a.reply_accepted === b.reply_accepted;
	endfunction

	always @(posedge clk) begin
		scre_pkg::out_item_t want;
		if (arst_n && pop && !empty) begin
			if (awaited_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result at cycle %0d: st=%0d", cycles, result.status);
			end else begin
				want = awaited_responses.pop_front();
				if (!same_result(want, result)) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("result mismatch at cycle %0d", cycles);
						$display("  expected st=%0d rr=%0d tx=%0b %h_%h acc=%0b",
							want.status, want.reject_reason, want.tx_valid,
							want.tx_frame_high, want.tx_frame_low, want.reply_accepted);
						$display("  got      st=%0d rr=%0d tx=%0b %h_%h acc=%0b",
							result.status, result.reject_reason, result.tx_valid,
							result.tx_frame_high, result.tx_frame_low, result.reply_accepted);
					end
				end
			end
		end
	end

	task automatic reset_model();
		for (int i = 0; i < QDEPTH; i++)
			cmd_mem[i] = '0;
		rd_ptr        = 0;
		wr_ptr        = 0;
		fill          = 0;
		seq_no        = '0;
		head_retries  = '0;
		wait_active   = 1'b0;
		wait_left     = '0;
		wait_setting  = scre_pkg::RETRY_WAIT_RST;
		retry_setting = scre_pkg::RETRY_LIMIT_RST;
	endtask

	task automatic drop_head();
		rd_ptr       = (rd_ptr + 1) % QDEPTH;
		fill--;
		head_retries = '0;
	endtask

	task automatic offer_head(inout scre_pkg::out_item_t r);
		if (fill != 0 && !wait_active) begin
			r.tx_valid = 1'b1;
			{r.tx_frame_high, r.tx_frame_low} = cmd_mem[rd_ptr];
		end
	endtask

	task automatic compute_response(input scre_pkg::in_item_t it,
		output scre_pkg::out_item_t r);
		logic [scre_pkg::FRAME_W-1:0] f, cmd, head;
		int unsigned n;
		bit was_empty;
		f = {it.frame_high, it.frame_low};
		r = '0;
		r.status = scre_pkg::ST_TICK;
		case (it.opcode)
			scre_pkg::OPC_QUEUE: begin
				if (fill >= QDEPTH) begin
					r.status = scre_pkg::ST_FULL;
				end else begin
					n = int'((it.cmd_length > scre_pkg::MAX_LEN) ? scre_pkg::MAX_LEN
						: it.cmd_length);
					seq_no++;
					cmd = '1;
					for (int i = 0; i < scre_pkg::BODY_BYTES; i++)
						if (i < n)
							cmd[8*i +: 8] = f[8*i +: 8];
					cmd[15:8]  = seq_no;
					cmd[95:88] = body_sum(cmd);
					was_empty = (fill == 0);
					cmd_mem[wr_ptr] = cmd;
					wr_ptr = (wr_ptr + 1) % QDEPTH;
					fill++;
					r.status = scre_pkg::ST_QUEUED;
					if (was_empty)
						offer_head(r);
				end
			end
			scre_pkg::OPC_REPLY: begin
				if (fill == 0) begin
					r.status = scre_pkg::ST_UNSOLICITED;
				end else begin
					head = cmd_mem[rd_ptr];
					if (f[95:88] != body_sum(f)) begin
						drop_head();
						r.status = scre_pkg::ST_BAD_CSUM;
					end else if ((f[7:0] & scre_pkg::REJECT_MASK) == scre_pkg::REJECT_MASK) begin
						r.reject_reason = f[3:0];
						r.status = scre_pkg::ST_REJECTED;
						if (!wait_active) begin
							if (int'(head_retries) + 1 > int'(retry_setting)) begin
								drop_head();
								r.status = scre_pkg::ST_ABORTED;
							end else begin
								head_retries++;
								wait_active = 1'b1;
								wait_left   = wait_setting;
							end
						end
					end else begin
						drop_head();
						if (f[7:0] != head[7:0])
							r.status = scre_pkg::ST_BAD_ID;
						else if (f[15:8] != head[15:8])
							r.status = scre_pkg::ST_BAD_SEQ;
						else begin
							r.status = scre_pkg::ST_ACCEPTED;
							r.reply_accepted = 1'b1;
						end
					end
				end
				offer_head(r);
			end
			scre_pkg::OPC_TICK: begin
				if (wait_active) begin
					if (wait_left <= 16'd1) begin
						wait_left   = '0;
						wait_active = 1'b0;
						offer_head(r);
					end else begin
						wait_left--;
					end
				end
			end
			default: ;
		endcase
	endtask

	// item held on the port from a falling edge until taken at a rising edge
	task automatic send_item(input scre_pkg::in_item_t it);
		scre_pkg::out_item_t r;
		@(negedge clk);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		compute_response(it, r);
		awaited_responses.push_back(r);
	endtask

	task automatic wait_for_drain();
		@(negedge clk);
		push <= 1'b0;
		while (awaited_responses.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_for_drain();
		repeat (10) @(posedge clk);
	endtask

	task automatic set_register(input logic idx, input logic [scre_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == scre_pkg::CFG_RETRY_WAIT)
			wait_setting = value;
		else
			retry_setting = value[3:0];
	endtask

	function automatic scre_pkg::in_item_t command_item(
		input logic [scre_pkg::FRAME_W-1:0] f, input logic [3:0] len);
		scre_pkg::in_item_t it;
		it = '0;
		it.opcode = scre_pkg::OPC_QUEUE;
		{it.frame_high, it.frame_low} = f;
		it.cmd_length = len;
		return it;
	endfunction

	function automatic scre_pkg::in_item_t tick_item();
		scre_pkg::in_item_t it;
		it = '0;
		it.opcode = scre_pkg::OPC_TICK;
		{it.frame_high, it.frame_low} = {$urandom, $urandom, $urandom};
		it.cmd_length = 4'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic scre_pkg::in_item_t random_command();
		return command_item({$urandom, $urandom, $urandom}, 4'($urandom_range(0, 15)));
	endfunction

	// reply built against the current head so that most of them pass the checks
	function automatic scre_pkg::in_item_t reply_item(input reply_kind_t kind);
		scre_pkg::in_item_t it;
		logic [scre_pkg::FRAME_W-1:0] f;
		f = {$urandom, $urandom, $urandom};
		if (fill != 0)
			f[15:0] = cmd_mem[rd_ptr][15:0];
		case (kind)
			RP_BAD_ID:  f[7:0]  ^= 8'($urandom_range(1, 255));
			RP_BAD_SEQ: f[15:8] ^= 8'($urandom_range(1, 255));
			RP_REJECT:  f[7:4]  = 4'hf;
			default: ;
		endcase
		f[95:88] = body_sum(f);
		if (kind == RP_BAD_CSUM)
			f[95:88] ^= 8'($urandom_range(1, 255));
		if (kind == RP_NOISE)
			f = {$urandom, $urandom, $urandom};
		it = '0;
		it.opcode = scre_pkg::OPC_REPLY;
		{it.frame_high, it.frame_low} = f;
		it.cmd_length = 4'($urandom_range(0, 15));
		return it;
	endfunction

	function automatic scre_pkg::in_item_t random_item();
		scre_pkg::in_item_t it;
		int unsigned pick, sub;
		pick = $urandom_range(99);
		sub  = $urandom_range(99);
		if (wait_active && pick < 55)
			return tick_item();
		if (pick < ((fill > 12) ? 20 : 40))
			return random_command();
		if (pick < 88) begin
			if (sub < 50)      return reply_item(RP_GOOD);
			else if (sub < 60) return reply_item(RP_BAD_ID);
			else if (sub < 68) return reply_item(RP_BAD_SEQ);
			else if (sub < 76) return reply_item(RP_BAD_CSUM);
			else if (sub < 94) return reply_item(RP_REJECT);
			else               return reply_item(RP_NOISE);
		end
		if (pick < 96)
			return tick_item();
		it = tick_item();
		it.opcode = scre_pkg::KIND_NOP;
		return it;
	endfunction

	task automatic test_reply_checks();
		scre_pkg::in_item_t it;
		send_item(reply_item(RP_GOOD));             // nothing pending
		send_item(tick_item());                     // tick with no wait running
		it = '1;
		it.opcode = scre_pkg::KIND_NOP;
		send_item(it);
		send_item(command_item('0, scre_pkg::MAX_LEN));
		send_item(command_item('1, 4'd15));
		send_item(command_item({$urandom, $urandom, $urandom}, 4'd0));
		send_item(command_item({$urandom, $urandom, $urandom}, 4'd5));
		send_item(reply_item(RP_BAD_CSUM));
		send_item(reply_item(RP_BAD_ID));
		send_item(reply_item(RP_BAD_SEQ));
		send_item(reply_item(RP_GOOD));
	endtask

	task automatic test_reject_recovery();
		settle();
		set_register(scre_pkg::CFG_RETRY_WAIT, 16'd0);
		set_register(scre_pkg::CFG_RETRY_LIMIT, 16'd1);
		send_item(command_item({$urandom, $urandom, $urandom}, scre_pkg::MAX_LEN));
		send_item(reply_item(RP_REJECT));           // starts the wait
		send_item(reply_item(RP_REJECT));           // reject while waiting
		send_item(tick_item());                     // zero wait ends at once, resend
		send_item(reply_item(RP_REJECT));           // over the limit, dropped
		settle();
		set_register(scre_pkg::CFG_RETRY_LIMIT, 16'd0);
		send_item(random_command());
		send_item(reply_item(RP_REJECT));
	endtask

	task automatic test_long_wait();
		settle();
		set_register(scre_pkg::CFG_RETRY_WAIT, 16'd40);
		set_register(scre_pkg::CFG_RETRY_LIMIT, 16'd15);
		idle_pct  = 0;
		stall_pct = 0;
		send_item(random_command());
		send_item(reply_item(RP_REJECT));
		send_item(random_command());
		send_item(reply_item(RP_GOOD));             // head leaves, next held by the wait
		while (wait_active)
			send_item(tick_item());
		send_item(reply_item(RP_GOOD));
	endtask

	task automatic test_queue_full();
		for (int i = 0; i <= QDEPTH; i++)
			send_item(random_command());
	endtask

	task automatic test_random_traffic(input int unsigned sender_idle, input int unsigned rx_stall,
		input logic [15:0] wait_ticks, input logic [3:0] limit);
		settle();
		set_register(scre_pkg::CFG_RETRY_WAIT, wait_ticks);
		set_register(scre_pkg::CFG_RETRY_LIMIT, {12'd0, limit});
		idle_pct  = sender_idle;
		stall_pct = rx_stall;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_for_drain();
			send_item(random_item());
		end
	endtask

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reply_checks();
		test_reject_recovery();
		test_long_wait();
		test_queue_full();
		test_random_traffic(0, 0, 16'd1, 4'd15);
		test_random_traffic(53, 0, 16'd3, 4'd3);
		test_random_traffic(0, 53, 16'd2, 4'd0);
		test_random_traffic(17, 17, 16'd5, 4'd2);

		settle();
		if (mismatches == 0)
			$display("PASS serial_command_retry_engine_top");
		else
			$display("FAIL serial_command_retry_engine_top");
		$finish;
	end

endmodule
